// File: hw/rtl/stq_pkg.sv
// Package for the sorted timer queue: sizes, codes, control structs and helpers.
// Used by stq_ctrl, stq_dp and sorted_timer_queue_unit.
`default_nettype none
package stq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = 5;
  localparam int TICKS_W = 32;
  localparam int TAG_W   = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    decode;
    status_t set_status;
    logic    age;
    logic    place;
    logic    pop;
    logic    load_out;
  } stq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
    logic out_busy;
  } stq_stat_t;

  function automatic logic [TICKS_W-1:0] sat_sub(input logic [TICKS_W-1:0] a,
                                                 input logic [TICKS_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stq_ctrl.sv
// Sequencer for the sorted timer queue: decode, age, place or pop, then result.
// Depends on stq_pkg; drives stq_dp through stq_cmd_t.
`default_nettype none
module stq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire stq_pkg::stq_stat_t stat,
  output stq_pkg::stq_cmd_t      cmd
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_AGE,
    S_PLACE,
    S_POP,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.set_status = ST_OK;
    state_next     = state;
    case (state)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.kind == KIND_INSERT) begin
          if (stat.full) begin
            cmd.set_status = ST_FULL;
            state_next     = S_RESULT;
          end else begin
            state_next = S_AGE;
          end
        end else begin
          if (stat.empty) begin
            cmd.set_status = ST_EMPTY;
            state_next     = S_RESULT;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_AGE: begin
        cmd.age    = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_RESULT;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b1;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/stq_dp.sv
// Datapath for the sorted timer queue: entry cells, operand and output registers.
// Depends on stq_pkg; commanded by stq_ctrl.
`default_nettype none
module stq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stq_pkg::stq_cmd_t             cmd,
  output stq_pkg::stq_stat_t                 stat,
  input  wire logic                          kind,
  input  wire logic [stq_pkg::TICKS_W-1:0]   ticks,
  input  wire logic [stq_pkg::TAG_W-1:0]     tag,
  input  wire logic [stq_pkg::TICKS_W-1:0]   remaining,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stq_pkg::TICKS_W-1:0]        head_ticks,
  output logic [stq_pkg::TAG_W-1:0]          popped_tag,
  output logic [1:0]                         status,
  output logic [stq_pkg::CNT_W-1:0]          count
);
  import stq_pkg::*;

  logic [TICKS_W-1:0] entry_ticks [DEPTH];
  logic [TAG_W-1:0]   entry_tag   [DEPTH];
  logic [TICKS_W-1:0] ticks_next  [DEPTH];
  logic [TAG_W-1:0]   tag_next    [DEPTH];
  logic [DEPTH-1:0]   ge;
  logic [CNT_W-1:0]   cnt;

  logic               op_kind;
  logic [TICKS_W-1:0] op_ticks;
  logic [TAG_W-1:0]   op_tag;
  logic [TICKS_W-1:0] op_remaining;
  logic [TICKS_W-1:0] elapsed;
  logic [TICKS_W-1:0] pop_head;
  logic [TAG_W-1:0]   pop_tag;
  status_t            res_status;

  assign stat.kind     = op_kind;
  assign stat.full     = (cnt == CNT_W'(DEPTH));
  assign stat.empty    = (cnt == '0);
  assign stat.out_busy = out_valid && out_stall;

  // cells at or above the new entry's ticks, among those held
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < cnt) && (entry_ticks[i] >= op_ticks);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ticks_next[i] = entry_ticks[i];
      tag_next[i]   = entry_tag[i];
      if (cmd.age) begin
        ticks_next[i] = sat_sub(entry_ticks[i], elapsed);
      end else if (cmd.place) begin
        if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
          ticks_next[i] = entry_ticks[(i > 0) ? i - 1 : 0];
          tag_next[i]   = entry_tag[(i > 0) ? i - 1 : 0];
        end else if (ge[i] || (CNT_W'(i) == cnt)) begin
          ticks_next[i] = op_ticks;
          tag_next[i]   = op_tag;
        end
      end else if (cmd.pop) begin
        if (i < DEPTH - 1) begin
          ticks_next[i] = sat_sub(entry_ticks[(i < DEPTH - 1) ? i + 1 : i], entry_ticks[0]);
          tag_next[i]   = entry_tag[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_ticks[i] <= ticks_next[i];
      entry_tag[i]   <= tag_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind      <= kind;
      op_ticks     <= ticks;
      op_tag       <= tag;
      op_remaining <= remaining;
    end
    if (cmd.decode) begin
      elapsed    <= sat_sub(entry_ticks[0], op_remaining);
      res_status <= cmd.set_status;
      pop_head   <= '0;
      pop_tag    <= '0;
    end
    if (cmd.pop) begin
      pop_head <= entry_ticks[0];
      pop_tag  <= entry_tag[0];
    end
    if (cmd.load_out) begin
      head_ticks <= (op_kind == KIND_POP) ? pop_head : entry_ticks[0];
      popped_tag <= pop_tag;
      status     <= res_status;
      count      <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.place) cnt <= cnt + 1'b1;
      else if (cmd.pop) cnt <= cnt - 1'b1;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sorted_timer_queue_unit.sv
// Sorted timer queue, top level: stq_ctrl sequencer plus stq_dp datapath.
// Depends on stq_pkg, stq_ctrl and stq_dp.
//
// Holds up to 16 timer entries sorted by ticks remaining, each with a tag.
// Input channel (in_valid / in_stall): kind 0 inserts (ticks, tag) after aging
// all entries by the head's ticks minus remaining; kind 1 pops the head and
// ages the rest by its ticks. Output channel (out_valid / out_stall): one
// transaction per input with head_ticks, popped_tag, status and count.
// From input accept to out_valid, an insert steps through decode, age, place
// and result; a pop through decode, pop and result; a dropped insert or empty
// pop through decode and result. One item is in work at a time: in_stall stays
// high until the result is loaded into the output register.
// The output register holds a result while out_stall is high; the next
// input is still accepted, and its result waits in the sequencer until the
// output register frees up.
// Reset (rst, synchronous) empties the queue and drops any pending output;
// in_stall is high for one cycle after reset.
`default_nettype none
module sorted_timer_queue_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic [stq_pkg::TICKS_W-1:0]   ticks,
  input  wire logic [stq_pkg::TAG_W-1:0]     tag,
  input  wire logic [stq_pkg::TICKS_W-1:0]   remaining,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stq_pkg::TICKS_W-1:0]        head_ticks,
  output logic [stq_pkg::TAG_W-1:0]          popped_tag,
  output logic [1:0]                         status,
  output logic [stq_pkg::CNT_W-1:0]          count
);
  import stq_pkg::*;

  stq_cmd_t  cmd;
  stq_stat_t stat;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  stq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .ticks      (ticks),
    .tag        (tag),
    .remaining  (remaining),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head_ticks (head_ticks),
    .popped_tag (popped_tag),
    .status     (status),
    .count      (count)
  );

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in work");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= CNT_W'(DEPTH)))
    else $error("count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == CNT_W'(DEPTH) && popped_tag == '0))
    else $error("full status with queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (count == '0 && head_ticks == '0))
    else $error("empty status with nonzero fields");

  a_no_reserved_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("reserved status code");
`endif

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for sorted_timer_queue_unit: a shadow sorted queue predicts
// every result and the monitor compares each output transaction field by field.
// Depends on stq_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module tb;
  import stq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic               kind;
    logic [TICKS_W-1:0] ticks;
    logic [TAG_W-1:0]   tag;
    logic [TICKS_W-1:0] remaining;
  } timer_op_t;

  typedef struct {
    logic [TICKS_W-1:0] head_ticks;
    logic [TAG_W-1:0]   popped_tag;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_INSERT;
  logic [TICKS_W-1:0] ticks = '0;
  logic [TAG_W-1:0] tag = '0;
  logic [TICKS_W-1:0] remaining = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TICKS_W-1:0] head_ticks;
  logic [TAG_W-1:0] popped_tag;
  logic [1:0] status;
  logic [CNT_W-1:0] count;

  timer_op_t ops_to_send[$];
  timer_result_t awaited_results[$];
  timer_op_t drv_op;
  timer_result_t got_exp;

  logic [TICKS_W-1:0] shadow_ticks[DEPTH];
  logic [TAG_W-1:0] shadow_tags[DEPTH];
  int shadow_count = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  bit in_took = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  sorted_timer_queue_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .ticks(ticks), .tag(tag), .remaining(remaining),
    .out_valid(out_valid), .out_stall(out_stall),
    .head_ticks(head_ticks), .popped_tag(popped_tag), .status(status), .count(count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TICKS_W-1:0] floor_sub(input logic [TICKS_W-1:0] a,
                                                   input logic [TICKS_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // advances the shadow queue by one transaction and returns the result it produces
  function automatic timer_result_t compute_timer_result(input timer_op_t op);
    timer_result_t r;
    logic [TICKS_W-1:0] elapsed;
    int pos;
    int i;
    r.head_ticks = '0;
    r.popped_tag = '0;
    r.status = ST_OK;
    if (op.kind == KIND_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
        r.head_ticks = shadow_ticks[0];
      end else begin
        if (shadow_count > 0) begin
          elapsed = floor_sub(shadow_ticks[0], op.remaining);
          for (i = 0; i < shadow_count; i++)
            shadow_ticks[i] = floor_sub(shadow_ticks[i], elapsed);
        end
        pos = shadow_count;
        for (i = shadow_count - 1; i >= 0; i--)
          if (shadow_ticks[i] >= op.ticks) pos = i;
        for (i = shadow_count; i > pos; i--) begin
          shadow_ticks[i] = shadow_ticks[i-1];
          shadow_tags[i] = shadow_tags[i-1];
        end
        shadow_ticks[pos] = op.ticks;
        shadow_tags[pos] = op.tag;
        shadow_count++;
        r.head_ticks = shadow_ticks[0];
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.head_ticks = shadow_ticks[0];
      r.popped_tag = shadow_tags[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_ticks[i-1] = shadow_ticks[i];
        shadow_tags[i-1] = shadow_tags[i];
      end
      shadow_count--;
      for (i = 0; i < shadow_count; i++)
        shadow_ticks[i] = floor_sub(shadow_ticks[i], r.head_ticks);
    end
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // driver: a new transaction only once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_op = ops_to_send.pop_front();
        kind <= drv_op.kind;
        ticks <= drv_op.ticks;
        tag <= drv_op.tag;
        remaining <= drv_op.remaining;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a single long hold-off when armed
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: head_ticks %0h popped_tag %0h status %0d count %0d",
                   $time, head_ticks, popped_tag, status, count);
          mismatches++;
        end else begin
          got_exp = awaited_results.pop_front();
          check_field("head_ticks", got_exp.head_ticks, head_ticks);
          check_field("popped_tag", 32'(got_exp.popped_tag), 32'(popped_tag));
          check_field("status", 32'(got_exp.status), 32'(status));
          check_field("count", 32'(got_exp.count), 32'(count));
        end
      end
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        awaited_results.push_back(compute_timer_result('{kind, ticks, tag, remaining}));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic push_op(input logic k, input logic [TICKS_W-1:0] t,
                         input logic [TAG_W-1:0] g, input logic [TICKS_W-1:0] rem);
    timer_op_t op;
    op.kind = k;
    op.ticks = t;
    op.tag = g;
    op.remaining = rem;
    ops_to_send.push_back(op);
  endtask

  function automatic logic [TICKS_W-1:0] rand_ticks();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(63);
      4, 5, 6:    return $urandom_range(100000);
      7:          return $urandom;
      8:          return 32'hFFFF_FFFF - $urandom_range(63);
      default:    return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // runs biased toward filling, draining or neither
  task automatic add_random_ops(input int n);
    int left;
    int run;
    int ins_pct;
    left = n;
    run = 0;
    ins_pct = 50;
    while (left > 0) begin
      if (run == 0) begin
        run = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: ins_pct = 85;
          1: ins_pct = 20;
          default: ins_pct = 55;
        endcase
      end
      push_op(($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_POP,
              rand_ticks(), 8'($urandom), rand_ticks());
      run--;
      left--;
    end
  endtask

  task automatic wait_drained();
    while (ops_to_send.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    stall_pct = stall;
    add_random_ops(n);
    wait_drained();
  endtask

  initial begin
    int i;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_op(KIND_POP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    push_op(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'h0);
    push_op(KIND_INSERT, 32'h0, 8'h00, 32'hFFFF_FFFF);
    push_op(KIND_POP, 32'h0, 8'h00, 32'h0);
    push_op(KIND_INSERT, 32'd1000, 8'h01, 32'hFFFF_FFFF);
    push_op(KIND_INSERT, 32'd1000, 8'h02, 32'd400);
    push_op(KIND_INSERT, 32'd400, 8'h03, 32'd400);
    push_op(KIND_INSERT, 32'd5, 8'h04, 32'h0);
    for (i = 0; i < 11; i++)
      push_op(KIND_INSERT, (i % 4) * 10, 8'h10 + i[7:0],
              (i % 3 == 0) ? 32'h0 : 32'hFFFF_FFFF);
    push_op(KIND_INSERT, 32'h0, 8'hAA, 32'h0);
    for (i = 0; i < 5; i++)
      push_op(KIND_POP, 32'h0, 8'h00, 32'h0);
    wait_drained();

    run_phase(0, 0, 180);
    run_phase(78, 0, 180);
    run_phase(0, 78, 180);
    run_phase(27, 27, 180);
    hold_armed = 1'b1;
    run_phase(0, 0, 180);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// File: sorted_timer_queue_unit.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_ctrl.sv
hw/rtl/stq_dp.sv
hw/rtl/sorted_timer_queue_unit.sv
verif/tb.sv
